// ===== src/llas_pkg.sv =====
// ---------------------------------------------------------------------------
// llas_pkg: shared types and constants for the life-like automaton step
// Register map, configuration bundle and neighborhood bundle used by the
// register block, the rule evaluator and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package llas_pkg;

  // Field widths fixed by the stream and register formats
  localparam int GRID_W      = 12;
  localparam int POS_W       = 11;
  localparam int ROW_LIMIT   = 2048;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_START_ROW   = 3'd2,
    REG_START_COL   = 3'd3,
    REG_GOAL_ROW    = 3'd4,
    REG_GOAL_COL    = 3'd5
  } reg_idx_t;

  // Configuration register contents
  typedef struct packed {
    logic [GRID_W-1:0] grid_width;
    logic [GRID_W-1:0] grid_height;
    logic [POS_W-1:0]  start_row;
    logic [POS_W-1:0]  start_col;
    logic [POS_W-1:0]  goal_row;
    logic [POS_W-1:0]  goal_col;
  } cfg_t;

  // 3x3 neighborhood: each column has bit0 = row above, bit1 = center row,
  // bit2 = row below; the ok flags mark which neighbors lie inside the grid
  typedef struct packed {
    logic [2:0] left;
    logic [2:0] mid;
    logic [2:0] right;
    logic       top_ok;
    logic       bot_ok;
    logic       left_ok;
    logic       right_ok;
  } nbhd_t;

endpackage

`default_nettype wire

// ===== src/llas_regs.sv =====
// ---------------------------------------------------------------------------
// llas_regs: configuration register block
// APB-style slave holding grid size and the two cells forced dead.
// ---------------------------------------------------------------------------
`default_nettype none

module llas_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [llas_pkg::APB_AW-1:0]    paddr,
  input  wire logic [llas_pkg::APB_DW-1:0]    pwdata,
  output logic      [llas_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  output llas_pkg::cfg_t                      cfg
);

  logic              wr_en;
  llas_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = llas_pkg::reg_idx_t'(paddr[llas_pkg::APB_AW-1:2]);

  // Write registers on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= llas_pkg::GRID_W'(llas_pkg::ROW_LIMIT);
      cfg.grid_height <= llas_pkg::GRID_W'(llas_pkg::ROW_LIMIT);
      cfg.start_row   <= '0;
      cfg.start_col   <= '0;
      cfg.goal_row    <= '0;
      cfg.goal_col    <= '0;
    end else if (wr_en) begin
      case (idx)
        llas_pkg::REG_GRID_WIDTH:  cfg.grid_width  <= pwdata[llas_pkg::GRID_W-1:0];
        llas_pkg::REG_GRID_HEIGHT: cfg.grid_height <= pwdata[llas_pkg::GRID_W-1:0];
        llas_pkg::REG_START_ROW:   cfg.start_row   <= pwdata[llas_pkg::POS_W-1:0];
        llas_pkg::REG_START_COL:   cfg.start_col   <= pwdata[llas_pkg::POS_W-1:0];
        llas_pkg::REG_GOAL_ROW:    cfg.goal_row    <= pwdata[llas_pkg::POS_W-1:0];
        llas_pkg::REG_GOAL_COL:    cfg.goal_col    <= pwdata[llas_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero for unused addresses
  always_comb begin
    case (idx)
      llas_pkg::REG_GRID_WIDTH:  prdata = llas_pkg::APB_DW'(cfg.grid_width);
      llas_pkg::REG_GRID_HEIGHT: prdata = llas_pkg::APB_DW'(cfg.grid_height);
      llas_pkg::REG_START_ROW:   prdata = llas_pkg::APB_DW'(cfg.start_row);
      llas_pkg::REG_START_COL:   prdata = llas_pkg::APB_DW'(cfg.start_col);
      llas_pkg::REG_GOAL_ROW:    prdata = llas_pkg::APB_DW'(cfg.goal_row);
      llas_pkg::REG_GOAL_COL:    prdata = llas_pkg::APB_DW'(cfg.goal_col);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/llas_rule.sv =====
// ---------------------------------------------------------------------------
// llas_rule: neighbor count and birth/survival rule
// Counts live neighbors inside the grid; a dead cell is born on 2 to 4,
// a live cell survives on 4 or 5.
// ---------------------------------------------------------------------------
`default_nettype none

module llas_rule (
  input  llas_pkg::nbhd_t nb,
  output logic            alive
);

  localparam logic [3:0] BIRTH_MIN = 4'd2;
  localparam logic [3:0] BIRTH_MAX = 4'd4;
  localparam logic [3:0] SURV_MIN  = 4'd4;
  localparam logic [3:0] SURV_MAX  = 4'd5;

  logic [2:0] rows;
  logic [2:0] left_m;
  logic [2:0] mid_m;
  logic [2:0] right_m;
  logic [3:0] count;

  // Mask rows and columns outside the grid, drop the center cell, count
  always_comb begin
    rows    = {nb.bot_ok, 1'b1, nb.top_ok};
    left_m  = nb.left_ok  ? (nb.left & rows)  : 3'b000;
    right_m = nb.right_ok ? (nb.right & rows) : 3'b000;
    mid_m   = nb.mid & rows & 3'b101;
    count   = 4'(left_m[0]) + 4'(left_m[1]) + 4'(left_m[2])
            + 4'(mid_m[0]) + 4'(mid_m[2])
            + 4'(right_m[0]) + 4'(right_m[1]) + 4'(right_m[2]);
    if (nb.mid[1]) begin
      alive = (count inside {[SURV_MIN:SURV_MAX]});
    end else begin
      alive = (count inside {[BIRTH_MIN:BIRTH_MAX]});
    end
  end

endmodule

`default_nettype wire

// ===== src/life_like_automaton_step_top.sv =====
// ---------------------------------------------------------------------------
// life_like_automaton_step_top: one automaton generation over a raster stream
// Pipeline: an accepted item passes the input register stage, and its result the output
//   register; the cell itself is emitted width+1 items after arrival.
// Throughput: one item per cycle while the output is not held back, set by the line store
//   read in the accept cycle and written back when the item leaves the input stage.
// Reset: position counters, 3x3 window and valid flags clear; line store
//   contents stay undefined and are masked by row position.
// ---------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_step_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // APB configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [llas_pkg::APB_AW-1:0]        paddr,
  input  wire logic [llas_pkg::APB_DW-1:0]        pwdata,
  output logic      [llas_pkg::APB_DW-1:0]        prdata,
  output logic                                    pready,
  // input cell stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [llas_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] cell_alive, [7:1] zero
  // output cell stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [llas_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] next_alive, [11:1] out_row,
                                                             // [22:12] out_col, [23] zero
  output logic                                    m_tlast    // last_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int IW = ((CW > llas_pkg::GRID_W) ? CW : llas_pkg::GRID_W) + 1;
  localparam int RW = llas_pkg::GRID_W;
  localparam int PW = llas_pkg::POS_W;

  llas_pkg::cfg_t  cfg;
  llas_pkg::nbhd_t nb;

  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  // arrival position of the next item
  logic [RW-1:0] arrival_row;
  logic [CW-1:0] arrival_col;
  logic [RW-1:0] arrival_row_next;
  logic [CW-1:0] arrival_col_next;

  logic          s_accept;
  logic          col_wrap;
  logic [RW-1:0] row_adj;
  logic [RW-1:0] acc_ar;
  logic [CW-1:0] acc_ac;
  logic          acc_v;
  logic          acc_frame_end;

  // input register stage
  logic          p1_valid;
  logic          p1_v;
  logic [RW-1:0] p1_ar;
  logic [CW-1:0] p1_ac;
  logic          p1_fire;
  logic          p1_emit;

  // line store: bit0 = row two above the arriving row, bit1 = row above
  logic [1:0]    line_mem [MAX_WIDTH];
  logic [1:0]    mem_q;
  logic          byp_sel;
  logic [1:0]    byp_data;
  logic [1:0]    rd_line;
  logic [1:0]    wr_line;

  logic [8:0]    window;
  logic [8:0]    window_next;
  logic [2:0]    column;

  logic          emit_last;
  logic          emit_cell;
  logic [RW-1:0] r_row;
  logic [IW-1:0] r_col;
  logic          rule_alive;
  logic          forced;
  logic          res_alive;
  logic          res_last;

  logic          out_alive;
  logic [PW-1:0] out_row;
  logic [PW-1:0] out_col;

  llas_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Clamp grid size into the supported range
  always_comb begin
    if (cfg.grid_width == '0) begin
      w_eff = WW'(1);
    end else if (IW'(cfg.grid_width) > IW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.grid_width);
    end
    if (cfg.grid_height == '0) begin
      h_eff = RW'(1);
    end else if (cfg.grid_height > RW'(llas_pkg::ROW_LIMIT)) begin
      h_eff = RW'(llas_pkg::ROW_LIMIT);
    end else begin
      h_eff = cfg.grid_height;
    end
  end

  // Place the arriving item in the grid and advance the position
  always_comb begin
    s_accept = s_tvalid && s_tready;
    col_wrap = IW'(arrival_col) >= IW'(w_eff);
    row_adj  = col_wrap ? (arrival_row + RW'(1)) : arrival_row;
    if (IW'(row_adj) > (IW'(h_eff) + IW'(1))) begin
      acc_ar = '0;
      acc_ac = '0;
    end else begin
      acc_ar = row_adj;
      acc_ac = col_wrap ? '0 : arrival_col;
    end
    acc_v         = (acc_ar < h_eff) ? s_tdata[0] : 1'b0;
    acc_frame_end = (acc_ac == '0) && (IW'(acc_ar) >= (IW'(h_eff) + IW'(1)));
    if (acc_frame_end) begin
      arrival_row_next = '0;
      arrival_col_next = '0;
    end else if ((IW'(acc_ac) + IW'(1)) >= IW'(w_eff)) begin
      arrival_row_next = acc_ar + RW'(1);
      arrival_col_next = '0;
    end else begin
      arrival_row_next = acc_ar;
      arrival_col_next = acc_ac + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_row <= '0;
      arrival_col <= '0;
    end else if (s_accept) begin
      arrival_row <= arrival_row_next;
      arrival_col <= arrival_col_next;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_accept) begin
      p1_valid <= 1'b1;
    end else if (p1_fire) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      p1_v  <= acc_v;
      p1_ar <= acc_ar;
      p1_ac <= acc_ac;
    end
  end

  // Read the line store on accept, write back the shifted column on fire
  always_ff @(posedge clk) begin
    if (p1_fire) begin
      line_mem[p1_ac] <= wr_line;
    end
    if (s_accept) begin
      mem_q <= line_mem[acc_ac];
    end
  end

  // Forward a write to the same column that lands in the read cycle
  always_ff @(posedge clk) begin
    if (s_accept) begin
      byp_sel  <= p1_fire && (p1_ac == acc_ac);
      byp_data <= wr_line;
    end
  end

  // Form the new column, shift the window and pick the cell to emit
  always_comb begin
    rd_line     = byp_sel ? byp_data : mem_q;
    column      = {p1_v, rd_line[1], rd_line[0]};
    wr_line     = {p1_v, rd_line[1]};
    window_next = {column, window[8:3]};
    emit_last   = (p1_ac == '0) && (p1_ar >= RW'(2));
    emit_cell   = (p1_ac != '0) && (p1_ar != '0) && (p1_ar <= h_eff);
    p1_emit     = emit_last || emit_cell;
    if (emit_last) begin
      r_row       = p1_ar - RW'(2);
      r_col       = IW'(w_eff) - IW'(1);
      nb.left     = window[5:3];
      nb.mid      = window[8:6];
      nb.right    = 3'b000;
      nb.left_ok  = IW'(w_eff) >= IW'(2);
      nb.right_ok = 1'b0;
    end else begin
      r_row       = p1_ar - RW'(1);
      r_col       = IW'(p1_ac) - IW'(1);
      nb.left     = window_next[2:0];
      nb.mid      = window_next[5:3];
      nb.right    = window_next[8:6];
      nb.left_ok  = IW'(p1_ac) >= IW'(2);
      nb.right_ok = IW'(p1_ac) < IW'(w_eff);
    end
    nb.top_ok = r_row != '0;
    nb.bot_ok = (r_row + RW'(1)) < h_eff;
    forced    = ((r_row == RW'(cfg.start_row)) && (r_col == IW'(cfg.start_col)))
             || ((r_row == RW'(cfg.goal_row)) && (r_col == IW'(cfg.goal_col)));
    res_alive = rule_alive && !forced;
    res_last  = (r_row == (h_eff - RW'(1))) && (r_col == (IW'(w_eff) - IW'(1)));
  end

  llas_rule u_rule (
    .nb    (nb),
    .alive (rule_alive)
  );

  // Advance the stage unless its result has no room
  assign p1_fire  = p1_valid && (!p1_emit || !m_tvalid || m_tready);
  assign s_tready = !p1_valid || p1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (p1_fire) begin
      window <= window_next;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p1_fire && p1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_fire && p1_emit) begin
      out_alive <= res_alive;
      out_row   <= r_row[PW-1:0];
      out_col   <= r_col[PW-1:0];
      m_tlast   <= res_last;
    end
  end

  assign m_tdata = {1'b0, out_col, out_row, out_alive};

  // An emitting item always leaves a result behind
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    p1_fire && p1_emit |=> m_tvalid)
    else $error("emitted result not presented");

  // Input side stalls only behind a held item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> p1_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // The frame-ending item restarts the position counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    s_accept && acc_frame_end |=> arrival_row == '0 && arrival_col == '0)
    else $error("position not reset after frame end");

endmodule

`default_nettype wire

// ===== test/life_step_checker.sv =====
// ---------------------------------------------------------------------------
// life_step_checker: scoreboard for the life-like automaton step
// Watches the register port and both cell streams, keeps its own copy of the
// grid configuration, line stores and 3x3 window, predicts the next-generation
// cell, if any, that each accepted input transaction completes, and compares each output
// transaction field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module life_step_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [llas_pkg::APB_AW-1:0]       paddr,
  input  logic [llas_pkg::APB_DW-1:0]       pwdata,
  input  logic [llas_pkg::APB_DW-1:0]       prdata,
  input  logic                              pready,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [llas_pkg::IN_TDATA_W-1:0]   s_tdata,   // [0] cell_alive, [7:1] zero
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [llas_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] next_alive, [11:1] out_row,
                                                       // [22:12] out_col, [23] zero
  input  logic                              m_tlast,   // last_of_frame
  output int                                errors,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import llas_pkg::*;

  // Rule thresholds: birth on 2..4 live neighbors, survival on 4..5
  localparam int BIRTH_MIN   = 2;
  localparam int BIRTH_MAX   = 4;
  localparam int SURVIVE_MIN = 4;
  localparam int SURVIVE_MAX = 5;

  typedef struct packed {
    logic             next_alive;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } cell_out_t;

  cfg_t        grid_cfg;
  bit          row_above_store  [MAX_WIDTH];
  bit          row_center_store [MAX_WIDTH];
  logic [8:0]  nbr_window;
  int unsigned next_row;
  int unsigned next_col;
  cell_out_t   next_gen_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_GRID_WIDTH:  return APB_DW'(grid_cfg.grid_width);
      REG_GRID_HEIGHT: return APB_DW'(grid_cfg.grid_height);
      REG_START_ROW:   return APB_DW'(grid_cfg.start_row);
      REG_START_COL:   return APB_DW'(grid_cfg.start_col);
      REG_GOAL_ROW:    return APB_DW'(grid_cfg.goal_row);
      REG_GOAL_COL:    return APB_DW'(grid_cfg.goal_col);
      default:         return '0;
    endcase
  endfunction

  task automatic store_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    case (idx)
      REG_GRID_WIDTH:  grid_cfg.grid_width  = value[GRID_W-1:0];
      REG_GRID_HEIGHT: grid_cfg.grid_height = value[GRID_W-1:0];
      REG_START_ROW:   grid_cfg.start_row   = value[POS_W-1:0];
      REG_START_COL:   grid_cfg.start_col   = value[POS_W-1:0];
      REG_GOAL_ROW:    grid_cfg.goal_row    = value[POS_W-1:0];
      REG_GOAL_COL:    grid_cfg.goal_col    = value[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Apply the outer-totalistic rule to one masked neighborhood
  function automatic bit next_state(nbhd_t nb, int unsigned r, int unsigned c);
    logic [2:0]  rows;
    logic [2:0]  lcol;
    logic [2:0]  mcol;
    logic [2:0]  rcol;
    int unsigned count;
    bit          alive;
    rows  = {nb.bot_ok, 1'b1, nb.top_ok};
    lcol  = nb.left_ok ? (nb.left & rows) : 3'b000;
    rcol  = nb.right_ok ? (nb.right & rows) : 3'b000;
    mcol  = nb.mid & rows;
    count = $countones(lcol) + $countones(mcol & 3'b101) + $countones(rcol);
    if (mcol[1]) alive = (count >= SURVIVE_MIN && count <= SURVIVE_MAX);
    else alive = (count >= BIRTH_MIN && count <= BIRTH_MAX);
    // start and goal cells never live
    if ((r == grid_cfg.start_row && c == grid_cfg.start_col) ||
        (r == grid_cfg.goal_row && c == grid_cfg.goal_col)) begin
      alive = 1'b0;
    end
    return alive;
  endfunction

  // Advance the raster position by one cell and queue the cell it completes
  task automatic predict_cell(bit cell_in);
    int unsigned w;
    int unsigned h;
    int unsigned ar;
    int unsigned ac;
    int unsigned r;
    int unsigned c;
    bit          v;
    bit          emit;
    bit          frame_end;
    bit          alive;
    logic [2:0]  column;
    nbhd_t       nb;
    cell_out_t   res;
    w = clamp_dim(grid_cfg.grid_width, MAX_WIDTH);
    h = clamp_dim(grid_cfg.grid_height, ROW_LIMIT);
    emit = 1'b0;
    frame_end = 1'b0;
    alive = 1'b0;
    r = 0;
    c = 0;
    // fold the position into a narrowed or shortened grid
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row > h + 1) begin
      next_row = 0;
      next_col = 0;
    end
    ar = next_row;
    ac = next_col;
    v  = (ar < h) ? cell_in : 1'b0;

    // last column of the row two back, from the window before the shift
    if (ac == 0) begin
      if (ar >= 2) begin
        r = ar - 2;
        c = w - 1;
        nb.left     = nbr_window[5:3];
        nb.mid      = nbr_window[8:6];
        nb.right    = 3'b000;
        nb.top_ok   = (r >= 1);
        nb.bot_ok   = (r + 1 < h);
        nb.left_ok  = (w >= 2);
        nb.right_ok = 1'b0;
        alive = next_state(nb, r, c);
        emit  = 1'b1;
      end
      if (ar >= h + 1) frame_end = 1'b1;
    end

    // shift the new column into the line stores and the window
    column = {v, row_center_store[ac], row_above_store[ac]};
    row_above_store[ac]  = row_center_store[ac];
    row_center_store[ac] = v;
    nbr_window = {column, nbr_window[8:3]};

    if (ac >= 1 && ar >= 1 && ar <= h) begin
      r = ar - 1;
      c = ac - 1;
      nb.left     = nbr_window[2:0];
      nb.mid      = nbr_window[5:3];
      nb.right    = nbr_window[8:6];
      nb.top_ok   = (r >= 1);
      nb.bot_ok   = (r + 1 < h);
      nb.left_ok  = (c >= 1);
      nb.right_ok = (c + 1 < w);
      alive = next_state(nb, r, c);
      emit  = 1'b1;
    end

    if (frame_end) begin
      next_row = 0;
      next_col = 0;
    end else if (ac + 1 >= w) begin
      next_col = 0;
      next_row = ar + 1;
    end else begin
      next_col = ac + 1;
    end

    if (emit) begin
      res.next_alive = alive;
      res.row        = r[POS_W-1:0];
      res.col        = c[POS_W-1:0];
      res.last       = (r == h - 1 && c == w - 1);
      next_gen_q.push_back(res);
    end
  endtask

  task automatic check_result();
    cell_out_t want;
    if (next_gen_q.size() == 0) begin
      $error("output transaction with no prediction: row %0d col %0d",
             m_tdata[11:1], m_tdata[22:12]);
      errors++;
    end else begin
      want = next_gen_q.pop_front();
      compare_field("next_alive", want.next_alive, m_tdata[0]);
      compare_field("out_row", want.row, m_tdata[11:1]);
      compare_field("out_col", want.col, m_tdata[22:12]);
      compare_field("last_of_frame", want.last, m_tlast);
    end
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      grid_cfg.grid_width  = GRID_W'(ROW_LIMIT);
      grid_cfg.grid_height = GRID_W'(ROW_LIMIT);
      grid_cfg.start_row   = '0;
      grid_cfg.start_col   = '0;
      grid_cfg.goal_row    = '0;
      grid_cfg.goal_col    = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above_store[i]  = 1'b0;
        row_center_store[i] = 1'b0;
      end
      nbr_window = '0;
      next_row   = 0;
      next_col   = 0;
      next_gen_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) store_reg(reg_idx_t'(paddr[4:2]), pwdata);
        else compare_field("prdata", reg_value(reg_idx_t'(paddr[4:2])), prdata);
      end
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) predict_cell(s_tdata[0]);
    end
    pending = next_gen_q.size();
  end

endmodule

// ===== test/tb_life_like_automaton_step_top.sv =====
// ---------------------------------------------------------------------------
// tb_life_like_automaton_step_top: stimulus for the life-like automaton step
// Configures grids over the register port, streams whole frames of cells
// (directed extremes and mid-frame resizes, then random frames and broken
// frames) under several idle and stall mixes, and reports the verdict from
// the checker's error count.
// ---------------------------------------------------------------------------
module tb_life_like_automaton_step_top;
  timeunit 1ns;
  timeprecision 1ps;
  import llas_pkg::*;

  localparam int MAX_WIDTH    = 2048;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 600000;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_AW-1:0]      paddr    = '0;
  logic [APB_DW-1:0]      pwdata   = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [0] cell_alive, [7:1] zero
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // [0] next_alive, [11:1] out_row,
                                           // [22:12] out_col, [23] zero
  logic                   m_tlast;         // last_of_frame

  int          check_errors;
  int          cells_pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_hold_go   = 1'b0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;

  always #5 clk = ~clk;

  life_like_automaton_step_top #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  life_step_checker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (check_errors),
    .pending  (cells_pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  task automatic apb_access(reg_idx_t idx, bit is_write, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program a whole grid and read every register back
  task automatic load_grid(int unsigned w, int unsigned h, int unsigned sr,
                           int unsigned sc, int unsigned gr, int unsigned gc);
    apb_access(REG_GRID_WIDTH, 1'b1, w);
    apb_access(REG_GRID_HEIGHT, 1'b1, h);
    apb_access(REG_START_ROW, 1'b1, sr);
    apb_access(REG_START_COL, 1'b1, sc);
    apb_access(REG_GOAL_ROW, 1'b1, gr);
    apb_access(REG_GOAL_COL, 1'b1, gc);
    apb_access(REG_GRID_WIDTH, 1'b0, '0);
    apb_access(REG_GRID_HEIGHT, 1'b0, '0);
    apb_access(REG_START_ROW, 1'b0, '0);
    apb_access(REG_START_COL, 1'b0, '0);
    apb_access(REG_GOAL_ROW, 1'b0, '0);
    apb_access(REG_GOAL_COL, 1'b0, '0);
  endtask

  // Offer one cell, with a random gap ahead of it
  task automatic send_cell(bit v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_cells(int unsigned n, int unsigned alive_pct);
    repeat (n) send_cell($urandom_range(99) < alive_pct);
  endtask

  // Drop valid and wait until every predicted cell has come out
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (cells_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One full frame: the grid cells, then width+1 flush items
  task automatic send_frame(int unsigned w_raw, int unsigned h_raw, int unsigned alive_pct);
    int unsigned w;
    int unsigned h;
    w = clamp_dim(w_raw, MAX_WIDTH);
    h = clamp_dim(h_raw, ROW_LIMIT);
    send_cells(w * h + w + 1, alive_pct);
    quiesce();
  endtask

  initial begin
    int unsigned base;
    int unsigned frame_no;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned pct;
    int unsigned sr;
    int unsigned sc;
    int unsigned gr;
    int unsigned gc;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames
    set_idling(0);
    // smallest grid, start and goal outside it
    load_grid(1, 1, 2047, 2047, 1500, 0);
    send_frame(1, 1, 100);
    // zero sizes count as one
    load_grid(0, 0, 5, 5, 0, 2047);
    send_frame(0, 0, 100);
    // all alive then all dead, goal on the last cell
    load_grid(4, 3, 0, 0, 2, 3);
    send_frame(4, 3, 100);
    send_frame(4, 3, 0);
    // start row and goal column past the grid
    load_grid(5, 4, 2047, 0, 0, 2047);
    send_frame(5, 4, 50);
    // narrow the grid in the middle of row two
    load_grid(6, 4, 1, 1, 3, 2);
    send_cells(15, 50);
    quiesce();
    apb_access(REG_GRID_WIDTH, 1'b1, 3);
    send_cells(7, 50);
    quiesce();
    // shorten the grid below the current row: restart the frame
    load_grid(3, 5, 0, 2, 4, 0);
    send_cells(12, 50);
    quiesce();
    apb_access(REG_GRID_HEIGHT, 1'b1, 2);
    send_frame(3, 2, 50);
    // width above the maximum, zero height
    load_grid(4095, 0, 0, 2047, 0, 1000);
    send_frame(4095, 0, 50);
    // height above the limit, zero width, long output hold-off
    load_grid(0, 4095, 1024, 0, 2047, 0);
    long_hold_go = 1'b1;
    send_frame(0, 4095, 50);

    // Random frames, some cut short by a height change
    base = items_sent;
    frame_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      set_idling(frame_no % 4);
      if ($urandom_range(99) < 85) begin
        w_raw = $urandom_range(0, 12);
        h_raw = $urandom_range(0, 12);
      end else begin
        w_raw = $urandom_range(13, 48);
        h_raw = $urandom_range(1, 3);
      end
      w = clamp_dim(w_raw, MAX_WIDTH);
      h = clamp_dim(h_raw, ROW_LIMIT);
      if ($urandom_range(99) < 70) begin
        sr = $urandom_range(0, h - 1);
        sc = $urandom_range(0, w - 1);
        gr = $urandom_range(0, h - 1);
        gc = $urandom_range(0, w - 1);
      end else begin
        sr = $urandom_range(0, 2047);
        sc = $urandom_range(0, 2047);
        gr = $urandom_range(0, 2047);
        gc = $urandom_range(0, 2047);
      end
      pct = $urandom_range(0, 100);
      load_grid(w_raw, h_raw, sr, sc, gr, gc);
      if (h >= 4 && $urandom_range(9) == 0) begin
        // break off at row three or later, then shrink below that row
        k = $urandom_range(3 * w, w * h - 1);
        send_cells(k, pct);
        quiesce();
        h = $urandom_range(1, k / w - 2);
        apb_access(REG_GRID_HEIGHT, 1'b1, h);
        send_frame(w, h, pct);
      end else begin
        send_frame(w_raw, h_raw, pct);
      end
      frame_no++;
    end

    quiesce();
    repeat (4 * SETTLE) @(negedge clk);
    if (check_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
src/llas_pkg.sv
src/llas_regs.sv
src/llas_rule.sv
src/life_like_automaton_step_top.sv
test/life_step_checker.sv
test/tb_life_like_automaton_step_top.sv
